[rtl/rmcu_pkg.sv]
// ---------------------------------------------------------------------------
// rmcu_pkg: shared types for the rational mediant and compare unit
// Transaction structs, controller states and the command and status bundles
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
package rmcu_pkg;

   localparam int FIELD_WIDTH        = 32;
   localparam int DEFAULT_WORD_WIDTH = 32;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] a_num;
      logic signed [FIELD_WIDTH-1:0] a_den;
      logic signed [FIELD_WIDTH-1:0] b_num;
      logic signed [FIELD_WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] sum_num;
      logic signed [FIELD_WIDTH-1:0] sum_den;
      logic                          a_less_b;
      logic                          a_equals_b;
      logic                          zero_denominator;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL_A,
      ST_MUL_B,
      ST_GCD_INIT,
      ST_GCD_DIV,
      ST_GCD_WAIT,
      ST_QUO_DIV,
      ST_QUO_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic {
      DIV_SRC_GCD,
      DIV_SRC_QUO
   } div_src_type;

   typedef struct packed {
      logic        load;
      logic        mul_a;
      logic        mul_b;
      logic        gcd_init;
      logic        div_start;
      div_src_type div_src;
      logic        gcd_step;
      logic        quo_store;
      logic        finish;
      logic        frac_sel;
      logic [1:0]  quo_idx;
   } cmd_type;

   typedef struct packed {
      logic zero_den;
      logic div_done;
      logic rem_zero;
   } status_type;

endpackage

[rtl/rmcu_divider.sv]
// ---------------------------------------------------------------------------
// rmcu_divider: iterative signed divider
// Truncating quotient and remainder, one quotient bit per cycle on the
// magnitudes, signs applied at the output. Quotient wraps to WORD_WIDTH.
// ---------------------------------------------------------------------------
module rmcu_divider import rmcu_pkg::*; #(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [WORD_WIDTH-1:0] dividend,
   input  logic signed [WORD_WIDTH-1:0] divisor,
   output logic signed [WORD_WIDTH-1:0] quotient,
   output logic signed [WORD_WIDTH-1:0] remainder,
   output logic                         done
);

   localparam int CW = $clog2(WORD_WIDTH + 1);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0] quot_ff, quot_in;
   logic [WORD_WIDTH-1:0] rem_ff, rem_in;
   logic [WORD_WIDTH-1:0] dmag_ff, dmag_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;
   logic [WORD_WIDTH:0]   shifted;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH-1:0] nmag;
   logic [WORD_WIDTH-1:0] dmag;

   // take magnitudes of the operands
   assign nmag = dividend[WORD_WIDTH-1] ? (~dividend + 1'b1) : dividend;
   assign dmag = divisor[WORD_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

   // one restoring step
   assign shifted = {rem_ff, quot_ff[WORD_WIDTH-1]};
   assign diff    = shifted - {1'b0, dmag_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      dmag_in   = dmag_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CW'(WORD_WIDTH);
         quot_in   = nmag;
         rem_in    = '0;
         dmag_in   = dmag;
         neg_q_in  = dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
         neg_r_in  = dividend[WORD_WIDTH-1];
      end else if (active_ff) begin
         quot_in = {quot_ff[WORD_WIDTH-2:0], ~diff[WORD_WIDTH]};
         rem_in  = diff[WORD_WIDTH] ? shifted[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff   <= cnt_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dmag_ff  <= dmag_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // apply signs, quotient wraps
   assign quotient  = neg_q_ff ? (~quot_ff + 1'b1) : quot_ff;
   assign remainder = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;
   assign done      = done_ff;

endmodule

[rtl/rmcu_datapath.sv]
// ---------------------------------------------------------------------------
// rmcu_datapath: operand, product, gcd and quotient registers
// Computes the wrapped sum at load, both cross-products in turn on one
// multiplier, and runs Euclid and the reductions through one divider.
// ---------------------------------------------------------------------------
module rmcu_datapath import rmcu_pkg::*; #(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int PW = 2 * WORD_WIDTH + 2;

   logic signed [WORD_WIDTH-1:0] op_ff [4];
   logic signed [WORD_WIDTH-1:0] sum_num_ff, sum_den_ff;
   logic                         zden_ff;
   logic signed [PW-1:0]         prod_a_ff, prod_b_ff;
   logic signed [WORD_WIDTH-1:0] eu_n_ff, eu_d_ff;
   logic signed [WORD_WIDTH-1:0] g_ff [2];
   logic signed [WORD_WIDTH-1:0] q_ff [4];
   logic                         valid_ff;
   rsp_type                      rsp_ff;

   logic signed [WORD_WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
   logic signed [WORD_WIDTH-1:0] sum_num_in, sum_den_in;
   logic                         one_zero;
   logic signed [WORD_WIDTH:0]   pan, pbn, pad, pbd;
   logic signed [WORD_WIDTH:0]   mul_x, mul_y;
   logic signed [PW-1:0]         product;
   logic signed [WORD_WIDTH-1:0] div_n, div_d;
   logic signed [WORD_WIDTH-1:0] div_q, div_r;
   logic                         div_done;
   logic                         less, equal;

   // low word of each input field
   assign in_an = req_data.a_num[WORD_WIDTH-1:0];
   assign in_ad = req_data.a_den[WORD_WIDTH-1:0];
   assign in_bn = req_data.b_num[WORD_WIDTH-1:0];
   assign in_bd = req_data.b_den[WORD_WIDTH-1:0];

   // mediant-style sum with wraparound
   assign one_zero = (in_an == '0) ^ (in_bn == '0);
   always_comb begin
      priority if (in_an == '0 && in_bn == '0) begin
         sum_num_in = '0;
         sum_den_in = WORD_WIDTH'(1);
      end else begin
         sum_num_in = in_an + in_bn;
         sum_den_in = in_ad + in_bd - WORD_WIDTH'(one_zero);
      end
   end

   // signs moved so denominators are positive, one bit wider for the most negative value
   assign pan = op_ff[1][WORD_WIDTH-1] ? -(WORD_WIDTH+1)'(op_ff[0]) : (WORD_WIDTH+1)'(op_ff[0]);
   assign pad = op_ff[1][WORD_WIDTH-1] ? -(WORD_WIDTH+1)'(op_ff[1]) : (WORD_WIDTH+1)'(op_ff[1]);
   assign pbn = op_ff[3][WORD_WIDTH-1] ? -(WORD_WIDTH+1)'(op_ff[2]) : (WORD_WIDTH+1)'(op_ff[2]);
   assign pbd = op_ff[3][WORD_WIDTH-1] ? -(WORD_WIDTH+1)'(op_ff[3]) : (WORD_WIDTH+1)'(op_ff[3]);

   // shared cross multiplier
   assign mul_x   = cmd.mul_a ? pan : pbn;
   assign mul_y   = cmd.mul_a ? pbd : pad;
   assign product = PW'(mul_x) * PW'(mul_y);

   // divider operand select
   always_comb begin
      unique case (cmd.div_src)
         DIV_SRC_GCD: begin
            div_n = eu_n_ff;
            div_d = eu_d_ff;
         end
         DIV_SRC_QUO: begin
            div_n = op_ff[cmd.quo_idx];
            div_d = g_ff[cmd.quo_idx[1]];
         end
         default: begin
            div_n = eu_n_ff;
            div_d = eu_d_ff;
         end
      endcase
   end

   rmcu_divider #(.WORD_WIDTH(WORD_WIDTH)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .quotient  (div_q),
      .remainder (div_r),
      .done      (div_done)
   );

   // hold operands and intermediate results
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff[0]   <= in_an;
         op_ff[1]   <= in_ad;
         op_ff[2]   <= in_bn;
         op_ff[3]   <= in_bd;
         sum_num_ff <= sum_num_in;
         sum_den_ff <= sum_den_in;
         zden_ff    <= (in_ad == '0) || (in_bd == '0);
      end
      if (cmd.mul_a) begin
         prod_a_ff <= product;
      end
      if (cmd.mul_b) begin
         prod_b_ff <= product;
      end
      if (cmd.gcd_init) begin
         eu_n_ff <= op_ff[{cmd.frac_sel, 1'b0}];
         eu_d_ff <= op_ff[{cmd.frac_sel, 1'b1}];
      end
      if (cmd.gcd_step) begin
         if (div_r == '0) begin
            g_ff[cmd.frac_sel] <= eu_d_ff;
         end else begin
            eu_n_ff <= eu_d_ff;
            eu_d_ff <= div_r;
         end
      end
      if (cmd.quo_store) begin
         q_ff[cmd.quo_idx] <= div_q;
      end
   end

   // assemble the result transaction
   assign less  = !zden_ff && (prod_a_ff < prod_b_ff);
   assign equal = !zden_ff && (q_ff[0] == q_ff[2]) && (q_ff[1] == q_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_ff.sum_num          <= FIELD_WIDTH'(sum_num_ff);
         rsp_ff.sum_den          <= FIELD_WIDTH'(sum_den_ff);
         rsp_ff.a_less_b         <= less;
         rsp_ff.a_equals_b       <= equal;
         rsp_ff.zero_denominator <= zden_ff;
      end
   end

   assign status.zero_den = zden_ff;
   assign status.div_done = div_done;
   assign status.rem_zero = (div_r == '0);
   assign rsp_valid       = valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

[rtl/rmcu_controller.sv]
// ---------------------------------------------------------------------------
// rmcu_controller: sequencer for one transaction
// Steps through load, cross-products, two Euclid loops and four reductions,
// then issues the result strobe; a zero denominator goes from setup straight to the strobe.
// ---------------------------------------------------------------------------
module rmcu_controller import rmcu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic       frac_sel_ff, frac_sel_in;
   logic [1:0] quo_idx_ff, quo_idx_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (start) state_in = ST_SETUP;
         ST_SETUP:    state_in = status.zero_den ? ST_FINISH : ST_MUL_A;
         ST_MUL_A:    state_in = ST_MUL_B;
         ST_MUL_B:    state_in = ST_GCD_INIT;
         ST_GCD_INIT: state_in = ST_GCD_DIV;
         ST_GCD_DIV:  state_in = ST_GCD_WAIT;
         ST_GCD_WAIT: begin
            if (status.div_done) begin
               priority if (!status.rem_zero) state_in = ST_GCD_DIV;
               else if (!frac_sel_ff)         state_in = ST_GCD_INIT;
               else                           state_in = ST_QUO_DIV;
            end
         end
         ST_QUO_DIV:  state_in = ST_QUO_WAIT;
         ST_QUO_WAIT: begin
            if (status.div_done) begin
               state_in = (quo_idx_ff == 2'd3) ? ST_FINISH : ST_QUO_DIV;
            end
         end
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // fraction and quotient counters
   always_comb begin
      frac_sel_in = frac_sel_ff;
      quo_idx_in  = quo_idx_ff;
      if (state_ff == ST_SETUP) begin
         frac_sel_in = 1'b0;
         quo_idx_in  = 2'd0;
      end
      if (state_ff == ST_GCD_WAIT && status.div_done && status.rem_zero) begin
         frac_sel_in = 1'b1;
      end
      if (state_ff == ST_QUO_WAIT && status.div_done) begin
         quo_idx_in = quo_idx_ff + 2'd1;
      end
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.frac_sel  = frac_sel_ff;
      cmd.quo_idx   = quo_idx_ff;
      cmd.div_src   = DIV_SRC_GCD;
      unique case (state_ff)
         ST_IDLE:     cmd.load = start;
         ST_MUL_A:    cmd.mul_a = 1'b1;
         ST_MUL_B:    cmd.mul_b = 1'b1;
         ST_GCD_INIT: cmd.gcd_init = 1'b1;
         ST_GCD_DIV:  cmd.div_start = 1'b1;
         ST_GCD_WAIT: cmd.gcd_step = status.div_done;
         ST_QUO_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_QUO;
         end
         ST_QUO_WAIT: cmd.quo_store = status.div_done;
         ST_FINISH:   cmd.finish = 1'b1;
         default:     cmd.load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         frac_sel_ff <= 1'b0;
         quo_idx_ff  <= 2'd0;
      end else begin
         state_ff    <= state_in;
         frac_sel_ff <= frac_sel_in;
         quo_idx_ff  <= quo_idx_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/rational_mediant_compare_unit.sv]
// ---------------------------------------------------------------------------
// rational_mediant_compare_unit: mediant sum, order and equality of two
// signed fractions
//
// Raise start with req_data while busy is low; the transaction is taken at
// that edge and busy rises. One result follows: rsp_valid is high for one
// cycle with rsp_data, and the receiver must take it then (no stall).
// The time per item is set mostly by the shared iterative divider. With a
// zero denominator the sequencer goes from setup straight to the strobe.
// Otherwise it runs one division per Euclid step of each fraction and one
// for each of the four reductions. busy drops in the cycle the strobe is
// shown, so the next start can be taken there.
// Synchronous reset returns the sequencer to idle and drops rsp_valid; no
// memory needs clearing.
// ---------------------------------------------------------------------------
module rational_mediant_compare_unit import rmcu_pkg::*; #(
   parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   rmcu_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rmcu_datapath #(.WORD_WIDTH(WORD_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // accepted transaction occupies the unit
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // result strobe coincides with return to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // zero denominator forces both comparisons low
   a_zden_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_denominator) |->
         (!rsp_data.a_less_b && !rsp_data.a_equals_b))
      else $error("comparison flag set with zero denominator");

   // divider is only started inside a transaction
   a_div_in_txn: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> busy)
      else $error("divider started while idle");

endmodule

[verif/rmcu_checker.sv]
// ---------------------------------------------------------------------------
// rmcu_checker: predictor and scoreboard for the mediant and compare unit
// Watches the command and result channels, computes the expected result of
// each accepted transaction and compares every strobed result against it.
// ---------------------------------------------------------------------------
module rmcu_checker import rmcu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      zero_den_seen,
   output int      equal_seen,
   output int      less_seen
);

   rsp_type expected_results[$];

   // Euclid gcd with truncating remainder; divisor is nonzero
   function automatic longint euclid_gcd(longint n, longint d);
      longint r;
      r = n % d;
      while (r != 0) begin
         n = d;
         d = r;
         r = n % d;
      end
      return d;
   endfunction

   function automatic rsp_type predict_fraction_ops(req_type t);
      rsp_type res;
      longint  an, ad, bn, bd, pan, pad, pbn, pbd, g1, g2;
      logic [31:0] qan, qad, qbn, qbd;
      an = longint'(t.a_num);
      ad = longint'(t.a_den);
      bn = longint'(t.b_num);
      bd = longint'(t.b_den);
      res = '0;
      // mediant-style sum, wrapping at the word
      if (an != 0 && bn != 0) begin
         res.sum_num = t.a_num + t.b_num;
         res.sum_den = t.a_den + t.b_den;
      end else if (an == 0 && bn == 0) begin
         res.sum_num = 0;
         res.sum_den = 1;
      end else begin
         res.sum_num = t.a_num + t.b_num;
         res.sum_den = t.a_den + t.b_den - 32'sd1;
      end
      if (ad == 0 || bd == 0) begin
         res.zero_denominator = 1'b1;
      end else begin
         pan = an; pad = ad; pbn = bn; pbd = bd;
         if (pad < 0) begin
            pan = -pan;
            pad = -pad;
         end
         if (pbd < 0) begin
            pbn = -pbn;
            pbd = -pbd;
         end
         res.a_less_b = (pan * pbd < pbn * pad);
         g1 = euclid_gcd(an, ad);
         g2 = euclid_gcd(bn, bd);
         // compare wrapped quotients, low word only
         qan = 32'(an / g1);
         qad = 32'(ad / g1);
         qbn = 32'(bn / g2);
         qbd = 32'(bd / g2);
         res.a_equals_b = (qan == qbn) && (qad == qbd);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
      fail_count++;
   endtask

   // compare the oldest expectation first, then queue the new transaction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count = 0;
         zero_den_seen = 0;
         equal_seen = 0;
         less_seen = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.sum_num !== want.sum_num)
                  report_mismatch("sum_num", rsp_data.sum_num, want.sum_num);
               if (rsp_data.sum_den !== want.sum_den)
                  report_mismatch("sum_den", rsp_data.sum_den, want.sum_den);
               if (rsp_data.a_less_b !== want.a_less_b)
                  report_mismatch("a_less_b", rsp_data.a_less_b, want.a_less_b);
               if (rsp_data.a_equals_b !== want.a_equals_b)
                  report_mismatch("a_equals_b", rsp_data.a_equals_b, want.a_equals_b);
               if (rsp_data.zero_denominator !== want.zero_denominator)
                  report_mismatch("zero_denominator", rsp_data.zero_denominator,
                                  want.zero_denominator);
               zero_den_seen += want.zero_denominator;
               equal_seen += want.a_equals_b;
               less_seen += want.a_less_b;
            end
         end
         if (start && !busy)
            expected_results.push_back(predict_fraction_ops(req_data));
      end
      pending = expected_results.size();
   end

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the rational mediant and compare unit
// Sends directed fraction pairs (extremes, zero denominators, zero
// numerators, equal and reversed fractions) and then random pairs with
// random idle bursts; a side checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top import rmcu_pkg::*; ();

   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_TAIL   = 100;
   localparam int STALL_LIMIT  = 20000;
   localparam logic signed [31:0] MAX_W = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_W = 32'sh80000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count, pending, zero_den_seen, equal_seen, less_seen;
   int      sent;
   int      idle_cycles;

   rational_mediant_compare_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   rmcu_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending), .zero_den_seen(zero_den_seen),
      .equal_seen(equal_seen), .less_seen(less_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1;
         2: return -1;
         3: return MAX_W;
         default: return MIN_W;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_small(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic req_type random_pair();
      req_type t;
      int k;
      case ($urandom_range(0, 9))
         0: begin
            t = {$urandom, $urandom, $urandom, $urandom};
         end
         1, 2, 3: begin
            t = {pick_small(50), pick_small(50), pick_small(50), pick_small(50)};
         end
         4, 5: begin
            // same value written twice, scaled by a random factor
            t.a_num = pick_small(200);
            t.a_den = pick_small(200);
            if (t.a_den == 0) t.a_den = 7;
            k = $urandom_range(1, 9);
            if ($urandom_range(0, 1)) k = -k;
            t.b_num = t.a_num * k;
            t.b_den = t.a_den * k;
         end
         6: begin
            t = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
         end
         7: begin
            t = {$urandom, $urandom, $urandom, $urandom};
            if ($urandom_range(0, 1)) t.a_num = 0;
            else t.b_num = 0;
         end
         default: begin
            t = {pick_small(32767), pick_small(32767), pick_small(32767),
                 pick_small(32767)};
         end
      endcase
      return t;
   endfunction

   // hold start until the block takes the transaction at a rising edge
   task automatic send_pair(req_type t);
      start <= 1'b1;
      req_data <= t;
      do @(negedge clock); while (busy);
      @(posedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      req_type directed[$];
      int gap;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         '{0, 1, 0, 1}, '{1, 2, 2, 4}, '{-1, 2, 1, -2}, '{MIN_W, -1, MIN_W, 1},
         '{MIN_W, 1, MIN_W, -1}, '{MAX_W, MAX_W, MIN_W, MIN_W}, '{3, 0, 1, 2},
         '{1, 2, 3, 0}, '{0, 0, 0, 0}, '{5, 1, 0, 3}, '{0, 7, 5, 3},
         '{-1, -1, -1, -1}, '{6, -4, -3, 2}, '{MIN_W, MIN_W, MAX_W, 1},
         '{1, MAX_W, 1, MIN_W}, '{2, 3, 3, 4}, '{3, 4, 2, 3}, '{MAX_W, 1, MAX_W, -1},
         '{-4, 6, 2, -3}, '{MIN_W, -1, MAX_W, 1}, '{832040, 514229, 1, 1}
      };
      foreach (directed[i]) send_pair(directed[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // drain fully once midway
         if (i == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            wait_drained();
         end
         send_pair(random_pair());
         if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;

      wait_drained();
      repeat (50) @(posedge clock);
      $display("sent %0d fraction pairs: %0d with a zero denominator", sent, zero_den_seen);
      $display("results with A below B: %0d, with equal fractions: %0d", less_seen, equal_seen);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
